[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop)
`define ASSERT_CLK(lbl, clk, prop)
`endif

`endif

[rtl/core/sca_pkg.sv]
package sca_pkg;

    localparam int DEF_POOL_BYTES   = 1048576;
    localparam int DEF_ARENA_BYTES  = 131072;
    localparam int DEF_HEADER_BYTES = 8;
    localparam int DEF_SIZE_CLASSES = 13;

    localparam int MAX_CLASSES = 13;
    localparam int CLS_W       = 4;
    localparam int CLASS_W     = 17;
    localparam int NEED_W      = 14;
    localparam int SIZE_W      = 18;
    localparam int ADDR_W      = 20;
    localparam int STATUS_W    = 2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd3;

    localparam logic [CLASS_W-1:0] CLASS_BYTES [MAX_CLASSES] = '{
        17'd16, 17'd32, 17'd64, 17'd128, 17'd256, 17'd1024, 17'd2048,
        17'd4096, 17'd8192, 17'd16384, 17'd32768, 17'd65536, 17'd131008
    };

    // block size in 8-byte units, rounded up
    localparam logic [NEED_W-1:0] CLASS_NEED_UNITS [MAX_CLASSES] = '{
        14'd2, 14'd4, 14'd8, 14'd16, 14'd32, 14'd128, 14'd256,
        14'd512, 14'd1024, 14'd2048, 14'd4096, 14'd8192, 14'd16376
    };

    typedef struct packed {
        logic clear_step;
        logic load;
        logic lookup;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
    } dp_status_t;

endpackage

[rtl/core/size_class_free_list_allocator.sv]
// Size-class free-list allocator.
// Input channel (s_valid/s_ready): one request word, s_cmd selects allocate or
// free, s_req_size is the payload size excluding header, s_user_addr the
// address to free. Result channel (m_valid/m_ready): m_block_addr (address
// past the header, zero on error and on free) and m_status.
// The lookup cycle reads the mark and link stores, the commit cycle writes
// them and the class heads; the next request may already be taken in the
// commit cycle, so requests overlap.
// Reset: the mark store is swept clear, one entry a cycle, over POOL_BYTES / 8
// entries (131072 at the defaults); s_ready stays low meanwhile. Class
// stacks and the arena start empty.
// Stall: a held result word is kept in the output register; the next request
// may still be taken and looked up, and its commit waits until the held word
// is taken, so s_ready drops while that commit is pending.
module size_class_free_list_allocator
    import sca_pkg::*;
#(
    parameter int POOL_BYTES   = DEF_POOL_BYTES,
    parameter int ARENA_BYTES  = DEF_ARENA_BYTES,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES,
    parameter int SIZE_CLASSES = DEF_SIZE_CLASSES
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_cmd,
    input  logic [SIZE_W-1:0]   s_req_size,
    input  logic [ADDR_W-1:0]   s_user_addr,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [ADDR_W-1:0]   m_block_addr,
    output logic [STATUS_W-1:0] m_status
);

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    sca_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    sca_datapath #(
        .POOL_BYTES   (POOL_BYTES),
        .ARENA_BYTES  (ARENA_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .SIZE_CLASSES (SIZE_CLASSES)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_cmd        (s_cmd),
        .s_req_size   (s_req_size),
        .s_user_addr  (s_user_addr),
        .m_block_addr (m_block_addr),
        .m_status     (m_status)
    );

endmodule

[rtl/core/sca_datapath.sv]
module sca_datapath
    import sca_pkg::*;
#(
    parameter int POOL_BYTES   = DEF_POOL_BYTES,
    parameter int ARENA_BYTES  = DEF_ARENA_BYTES,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES,
    parameter int SIZE_CLASSES = DEF_SIZE_CLASSES
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ctrl_cmd_t           cmd,
    output dp_status_t          stat,
    input  logic                s_cmd,
    input  logic [SIZE_W-1:0]   s_req_size,
    input  logic [ADDR_W-1:0]   s_user_addr,
    output logic [ADDR_W-1:0]   m_block_addr,
    output logic [STATUS_W-1:0] m_status
);

    localparam int POOL_UNITS   = POOL_BYTES / 8;
    localparam int UNIT_W       = $clog2(POOL_UNITS);
    localparam int STRIDE_UNITS = (ARENA_BYTES + 7) / 8;
    localparam int ARENA_UNITS  = ARENA_BYTES / 8;
    localparam int ARENA_COUNT  = POOL_BYTES / (STRIDE_UNITS * 8);
    localparam int IDX_W        = $clog2(ARENA_COUNT + 2);
    localparam int OFF_W        = $clog2(ARENA_UNITS + 1);

    // request capture
    logic              cmd_reg;
    logic [CLS_W-1:0]  class_reg;
    logic              too_large_reg;
    logic [UNIT_W-1:0] unit_reg;
    logic              bad_addr_reg;

    // lookup results
    logic              head_valid_q;
    logic [UNIT_W-1:0] head_top_q;
    logic              mark_q;
    logic [UNIT_W-1:0] link_q;
    logic              need_too_q;
    logic              exhausted_q;
    logic [UNIT_W-1:0] bump_base_q;
    logic [IDX_W-1:0]  bump_idx_q;
    logic [OFF_W-1:0]  bump_off_q;

    // state
    logic              heads_valid_reg [MAX_CLASSES];
    logic [UNIT_W-1:0] heads_unit_reg  [MAX_CLASSES];
    logic [IDX_W-1:0]  arena_idx_reg;
    logic [OFF_W-1:0]  arena_off_reg;
    logic              arena_open_reg;
    logic [UNIT_W-1:0] clr_cnt_reg;

    logic              marks [POOL_UNITS];
    logic [UNIT_W-1:0] links [POOL_UNITS];

    logic [ADDR_W-1:0]   block_addr_reg;
    logic [STATUS_W-1:0] status_reg;

    // request decode
    logic [SIZE_W:0]   total;
    logic [CLS_W-1:0]  cls;
    logic [ADDR_W-1:0] base_bytes;
    logic [21:0]       base_units;
    logic              bad_addr;

    always_comb begin
        total = {1'b0, s_req_size} + (SIZE_W + 1)'(HEADER_BYTES);
        cls   = CLS_W'(SIZE_CLASSES);
        for (int i = MAX_CLASSES - 1; i >= 0; i--) begin
            if (i < SIZE_CLASSES && total <= (SIZE_W + 1)'(CLASS_BYTES[i])) begin
                cls = CLS_W'(i);
            end
        end
        base_bytes = s_user_addr - ADDR_W'(HEADER_BYTES);
        base_units = {5'b0, base_bytes[ADDR_W-1:3]};
        bad_addr   = (s_user_addr < ADDR_W'(HEADER_BYTES)) || (base_bytes[2:0] != 3'b000) ||
                     (base_units >= 22'(POOL_UNITS));
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg       <= s_cmd;
            class_reg     <= cls;
            too_large_reg <= (cls >= CLS_W'(SIZE_CLASSES));
            unit_reg      <= base_units[UNIT_W-1:0];
            bad_addr_reg  <= bad_addr;
        end
    end

    // head select and bump planning
    logic                head_valid_sel;
    logic [UNIT_W-1:0]   head_top_sel;
    logic [NEED_W-1:0]   need;
    logic [OFF_W:0]      need_ext;
    logic [OFF_W:0]      sum_cur;
    logic [OFF_W:0]      sum_new;
    logic                fits;
    logic [IDX_W-1:0]    idx_new;
    logic [OFF_W-1:0]    off_new;
    logic [UNIT_W-1:0]   base_new;

    always_comb begin
        head_valid_sel = 1'b0;
        head_top_sel   = '0;
        need           = '0;
        if (class_reg < CLS_W'(MAX_CLASSES)) begin
            head_valid_sel = heads_valid_reg[class_reg];
            head_top_sel   = heads_unit_reg[class_reg];
            need           = CLASS_NEED_UNITS[class_reg];
        end
        need_ext = (OFF_W + 1)'(need);
        sum_cur  = {1'b0, arena_off_reg} + need_ext;
        fits     = arena_open_reg && (sum_cur <= (OFF_W + 1)'(ARENA_UNITS));
        if (fits) begin
            idx_new = arena_idx_reg;
            off_new = arena_off_reg;
        end else begin
            idx_new = arena_open_reg ? arena_idx_reg + IDX_W'(1) : '0;
            off_new = '0;
        end
        sum_new  = {1'b0, off_new} + need_ext;
        base_new = UNIT_W'(idx_new) * UNIT_W'(STRIDE_UNITS) + UNIT_W'(off_new);
    end

    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            head_valid_q <= head_valid_sel;
            head_top_q   <= head_top_sel;
            need_too_q   <= need_ext > (OFF_W + 1)'(ARENA_UNITS);
            exhausted_q  <= !fits && (idx_new >= IDX_W'(ARENA_COUNT));
            bump_base_q  <= base_new;
            bump_idx_q   <= idx_new;
            bump_off_q   <= sum_new[OFF_W-1:0];
        end
    end

    // commit decisions
    logic [STATUS_W-1:0] res_status;
    logic                res_ok;
    logic [UNIT_W-1:0]   base_sel;
    logic                head_we;
    logic                head_valid_new;
    logic [UNIT_W-1:0]   head_unit_new;
    logic                mark_set;
    logic                mark_clr;
    logic                link_wr;
    logic                arena_we;

    always_comb begin
        res_status     = ST_OK;
        res_ok         = 1'b0;
        base_sel       = head_top_q;
        head_we        = 1'b0;
        head_valid_new = 1'b0;
        head_unit_new  = head_top_q;
        mark_set       = 1'b0;
        mark_clr       = 1'b0;
        link_wr        = 1'b0;
        arena_we       = 1'b0;
        if (cmd_reg == CMD_FREE) begin
            priority if (bad_addr_reg || !mark_q) begin
                res_status = ST_BAD_FREE;
            end else if (too_large_reg) begin
                res_status = ST_TOO_LARGE;
            end else begin
                mark_clr       = 1'b1;
                link_wr        = 1'b1;
                head_we        = 1'b1;
                head_valid_new = 1'b1;
                head_unit_new  = unit_reg;
            end
        end else begin
            priority if (too_large_reg) begin
                res_status = ST_TOO_LARGE;
            end else if (head_valid_q) begin
                res_ok         = 1'b1;
                mark_set       = 1'b1;
                head_we        = 1'b1;
                head_valid_new = (link_q != head_top_q);
                head_unit_new  = link_q;
            end else if (need_too_q) begin
                res_status = ST_TOO_LARGE;
            end else if (exhausted_q) begin
                res_status = ST_EXHAUSTED;
            end else begin
                res_ok   = 1'b1;
                mark_set = 1'b1;
                arena_we = 1'b1;
                base_sel = bump_base_q;
            end
        end
    end

    // mark and link stores
    logic              mark_we;
    logic [UNIT_W-1:0] mark_waddr;
    logic              mark_wdata;
    logic              link_we;

    always_comb begin
        mark_we    = 1'b0;
        mark_waddr = clr_cnt_reg;
        mark_wdata = 1'b0;
        if (cmd.clear_step) begin
            mark_we = 1'b1;
        end else if (cmd.commit && (mark_set || mark_clr)) begin
            mark_we    = 1'b1;
            mark_waddr = mark_set ? base_sel : unit_reg;
            mark_wdata = mark_set;
        end
        link_we = cmd.commit && link_wr;
    end

    always_ff @(posedge aclk) begin
        if (mark_we) begin
            marks[mark_waddr] <= mark_wdata;
        end
        if (cmd.lookup) begin
            mark_q <= marks[unit_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (link_we) begin
            links[unit_reg] <= head_valid_q ? head_top_q : unit_reg;
        end
        if (cmd.lookup) begin
            link_q <= links[head_top_sel];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear_step) begin
            clr_cnt_reg <= clr_cnt_reg + UNIT_W'(1);
        end
    end

    assign stat.clear_last = (clr_cnt_reg == UNIT_W'(POOL_UNITS - 1));

    // class stacks and arena
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_CLASSES; i++) begin
                heads_valid_reg[i] <= 1'b0;
            end
            arena_idx_reg  <= '0;
            arena_off_reg  <= '0;
            arena_open_reg <= 1'b0;
        end else if (cmd.commit) begin
            if (head_we) begin
                heads_valid_reg[class_reg] <= head_valid_new;
            end
            if (arena_we) begin
                arena_idx_reg  <= bump_idx_q;
                arena_off_reg  <= bump_off_q;
                arena_open_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && head_we) begin
            heads_unit_reg[class_reg] <= head_unit_new;
        end
    end

    // result word
    logic [24:0] addr_calc;

    assign addr_calc = 25'({base_sel, 3'b000}) + 25'(HEADER_BYTES);

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            block_addr_reg <= res_ok ? addr_calc[ADDR_W-1:0] : '0;
            status_reg     <= res_status;
        end
    end

    assign m_block_addr = block_addr_reg;
    assign m_status     = status_reg;

endmodule

[rtl/core/sca_ctrl.sv]
`include "assert_macros.svh"

module sca_ctrl
    import sca_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output ctrl_cmd_t  cmd,
    input  dp_status_t stat
);

    typedef enum logic [1:0] {
        CLEAR,
        IDLE,
        LOOKUP,
        COMMIT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   commit_fire;

    always_comb begin
        commit_fire    = (state_reg == COMMIT) && (!m_valid_reg || m_ready);
        s_ready        = (state_reg == IDLE) || commit_fire;
        cmd.clear_step = (state_reg == CLEAR);
        cmd.load       = s_valid && s_ready;
        cmd.lookup     = (state_reg == LOOKUP);
        cmd.commit     = commit_fire;

        state_next = state_reg;
        unique case (state_reg)
            CLEAR: begin
                if (stat.clear_last) begin
                    state_next = IDLE;
                end
            end
            IDLE: begin
                if (cmd.load) begin
                    state_next = LOOKUP;
                end
            end
            LOOKUP: begin
                state_next = COMMIT;
            end
            COMMIT: begin
                if (commit_fire) begin
                    state_next = cmd.load ? LOOKUP : IDLE;
                end
            end
            default: begin
                state_next = CLEAR;
            end
        endcase

        if (commit_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    `ASSERT_CLK_RST(a_load_to_lookup, aclk, aresetn, cmd.load |=> (state_reg == LOOKUP))
    `ASSERT_CLK_RST(a_lookup_to_commit, aclk, aresetn, cmd.lookup |=> (state_reg == COMMIT))
    `ASSERT_CLK_RST(a_commit_gives_word, aclk, aresetn, cmd.commit |=> m_valid_reg)
    `ASSERT_CLK(a_reset_clears, aclk, !aresetn |=> (state_reg == CLEAR) && !m_valid_reg)

endmodule
